/* design/assert_macros.svh */
// Shared assertion helpers; every user has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/bleaps_pkg.sv */
`default_nettype none

package bleaps_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_DONE = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_SHUT = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_LEN,
        SRC_ID3,
        SRC_ID2,
        SRC_ID1,
        SRC_ID0,
        SRC_ANGLE,
        SRC_BATT
    } src_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ODD,
        JMP_END
    } jmp_t;

    typedef logic [5:0] upc_t;

    typedef struct packed {
        kind_t      kind;
        src_t       src;
        logic [7:0] konst;
        logic       last;
        jmp_t       jmp;
    } ucode_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] angle;
        logic [7:0] battery;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
        logic [6:0] rf_frequency;
        logic [5:0] whitening_channel;
        logic       converter_on;
        logic       oscillator_on;
    } out_word_t;

    localparam upc_t PC_TICK   = 6'd0;
    localparam upc_t PC_SHUT   = 6'd1;
    localparam upc_t PC_PRE    = 6'd2;
    localparam upc_t PC_NAME   = 6'd40;
    localparam upc_t PC_LIMIT  = 6'd56;

    localparam logic [7:0] LEN_NAME   = 8'd25;
    localparam logic [7:0] LEN_BEACON = 8'd36;

    localparam logic [7:0] THRESH_RESET = 8'd23;

    localparam logic [1:0] CHAN_LAST = 2'd2;

    function automatic ucode_t uw(input logic [7:0] b);
        return '{kind: KIND_BYTE, src: SRC_CONST, konst: b, last: 1'b0, jmp: JMP_NEXT};
    endfunction

    function automatic ucode_t us(input src_t s);
        return '{kind: KIND_BYTE, src: s, konst: 8'h00, last: 1'b0, jmp: JMP_NEXT};
    endfunction

    function automatic ucode_t ulast(input logic [7:0] b);
        return '{kind: KIND_BYTE, src: SRC_CONST, konst: b, last: 1'b1, jmp: JMP_END};
    endfunction

    // Microprogram: one entry per result word.
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        unique case (pc)
            6'd0:  w = '{kind: KIND_TICK, src: SRC_CONST, konst: 8'h00, last: 1'b1, jmp: JMP_END};
            6'd1:  w = '{kind: KIND_SHUT, src: SRC_CONST, konst: 8'h00, last: 1'b1, jmp: JMP_END};
            // header and address
            6'd2:  w = uw(8'h42);
            6'd3:  w = us(SRC_LEN);
            6'd4:  w = us(SRC_ID3);
            6'd5:  w = us(SRC_ID2);
            6'd6:  w = us(SRC_ID1);
            6'd7:  w = us(SRC_ID0);
            6'd8:  w = uw(8'h00);
            6'd9:  w = uw(8'h00);
            6'd10: w = uw(8'h02);
            6'd11: w = uw(8'h01);
            6'd12: w = '{kind: KIND_BYTE, src: SRC_CONST, konst: 8'h04, last: 1'b0, jmp: JMP_ODD};
            // beacon record
            6'd13: w = uw(8'h1A);
            6'd14: w = uw(8'hFF);
            6'd15: w = uw(8'h4C);
            6'd16: w = uw(8'h00);
            6'd17: w = uw(8'h02);
            6'd18: w = uw(8'h15);
            6'd19: w = uw(8'h3B);
            6'd20: w = uw(8'h0C);
            6'd21: w = uw(8'h44);
            6'd22: w = uw(8'hC6);
            6'd23: w = uw(8'h55);
            6'd24: w = uw(8'hA8);
            6'd25: w = uw(8'hF9);
            6'd26: w = uw(8'h55);
            6'd27: w = uw(8'h32);
            6'd28: w = uw(8'hEB);
            6'd29: w = uw(8'h6A);
            6'd30: w = uw(8'hB2);
            6'd31: w = uw(8'h65);
            6'd32: w = uw(8'h42);
            6'd33: w = uw(8'hFE);
            6'd34: w = uw(8'h1A);
            6'd35: w = uw(8'h00);
            6'd36: w = uw(8'h00);
            6'd37: w = us(SRC_ANGLE);
            6'd38: w = us(SRC_BATT);
            6'd39: w = ulast(8'hC5);
            // name record
            6'd40: w = uw(8'h0F);
            6'd41: w = uw(8'h08);
            6'd42: w = uw(8'h4F);
            6'd43: w = uw(8'h70);
            6'd44: w = uw(8'h65);
            6'd45: w = uw(8'h6E);
            6'd46: w = uw(8'h42);
            6'd47: w = uw(8'h65);
            6'd48: w = uw(8'h61);
            6'd49: w = uw(8'h63);
            6'd50: w = uw(8'h6F);
            6'd51: w = uw(8'h6E);
            6'd52: w = uw(8'h20);
            6'd53: w = uw(8'h54);
            6'd54: w = uw(8'h61);
            6'd55: w = ulast(8'h67);
            default: w = ulast(8'h00);
        endcase
        return w;
    endfunction

    function automatic logic [6:0] chan_freq(input logic [1:0] ch);
        logic [6:0] f;
        unique case (ch)
            2'd1:    f = 7'd26;
            2'd2:    f = 7'd80;
            default: f = 7'd2;
        endcase
        return f;
    endfunction

    function automatic logic [5:0] chan_white(input logic [1:0] ch);
        logic [5:0] c;
        unique case (ch)
            2'd1:    c = 6'd38;
            2'd2:    c = 6'd39;
            default: c = 6'd37;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/bleaps_seq.sv */
`default_nettype none

module bleaps_seq
    import bleaps_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   start,
    input  wire upc_t   start_pc,
    input  wire logic   step,
    input  wire logic   parity_odd,
    output logic        busy,
    output ucode_t      ctrl
);

    upc_t pc_reg, pc_next;
    logic busy_reg, busy_next;

    assign ctrl = ucode_rom(pc_reg);
    assign busy = busy_reg;

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start) begin
            pc_next   = start_pc;
            busy_next = 1'b1;
        end else if (step) begin
            unique case (ctrl.jmp)
                JMP_NEXT: pc_next = pc_reg + 6'd1;
                JMP_ODD:  pc_next = parity_odd ? PC_NAME : pc_reg + 6'd1;
                JMP_END:  busy_next = 1'b0;
                default:  busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= PC_TICK;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMP(a_pc_in_range, busy_reg, pc_reg < PC_LIMIT)
    `ASSERT_NXT(a_end_stops, step && ctrl.jmp == JMP_END, !busy_reg)
    `ASSERT_IMP(a_start_idle, start, !busy_reg)

endmodule

`default_nettype wire

/* design/bleaps_dp.sv */
`default_nettype none

module bleaps_dp
    import bleaps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire logic [7:0]  angle,
    input  wire logic [7:0]  battery,
    input  wire logic        step,
    input  wire ucode_t      ctrl,
    input  wire logic [31:0] device_id,
    input  wire logic [7:0]  threshold,
    input  wire logic        parity_odd,
    input  wire logic [1:0]  chan,
    input  wire logic        m_ready,
    output logic             m_valid,
    output out_word_t        m_data,
    output logic             out_free
);

    logic [7:0] angle_reg, batt_reg;
    logic       valid_reg, valid_next;
    out_word_t  data_reg, data_next;
    logic [7:0] byte_val;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        unique case (ctrl.src)
            SRC_LEN:   byte_val = parity_odd ? LEN_NAME : LEN_BEACON;
            SRC_ID3:   byte_val = device_id[31:24];
            SRC_ID2:   byte_val = device_id[23:16];
            SRC_ID1:   byte_val = device_id[15:8];
            SRC_ID0:   byte_val = device_id[7:0];
            SRC_ANGLE: byte_val = angle_reg;
            SRC_BATT:  byte_val = batt_reg;
            default:   byte_val = ctrl.konst;
        endcase
    end

    always_comb begin
        data_next      = '0;
        data_next.kind = ctrl.kind;
        data_next.last = ctrl.last;
        unique case (ctrl.kind)
            KIND_BYTE: begin
                data_next.data_byte         = byte_val;
                data_next.rf_frequency      = chan_freq(chan);
                data_next.whitening_channel = chan_white(chan);
            end
            KIND_TICK: begin
                data_next.converter_on  = (batt_reg >= threshold);
                data_next.oscillator_on = 1'b1;
            end
            default: begin
            end
        endcase
        valid_next = valid_reg;
        if (step) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            angle_reg <= angle;
            batt_reg  <= battery;
        end
        if (step) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* design/ble_advert_packet_sequencer_top.sv */
`default_nettype none

// channel   dir  handshake             word
// s_*       in   s_valid / s_ready     in_word_t  (cmd, angle, battery)
// m_*       out  m_valid / m_ready     out_word_t (one result per word)
// apb       in   psel/penable/pwrite   device_id @0x0, converter_threshold @0x4
//
// A tick or shutdown gives one word; a packet gives 27 (odd sequence) or 38
// (even sequence) words, one per cycle while m_ready holds.
// The microcode step counter emits one word per step; s_ready is low from
// the accepting edge until the step that loads the last word.
// The output register lets the next word be accepted while that last word waits.
// Synchronous active-low reset; no clearing pass.
module ble_advert_packet_sequencer_top
    import bleaps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] id_reg;
    logic [7:0]  thr_reg;
    logic        parity_reg, parity_next;
    logic [1:0]  chan_reg, chan_next;

    logic   accept, start, step, busy, out_free, cfg_wr;
    upc_t   start_pc;
    ucode_t ctrl;
    cmd_t   cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {24'd0, thr_reg} : id_reg;

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_data.cmd);
    assign step    = busy && out_free;

    always_comb begin
        parity_next = parity_reg;
        chan_next   = chan_reg;
        start       = 1'b0;
        start_pc    = PC_TICK;
        if (accept) begin
            unique case (cmd)
                CMD_TICK: begin
                    parity_next = !parity_reg;
                    chan_next   = 2'd0;
                    start       = 1'b1;
                    start_pc    = PC_TICK;
                end
                CMD_SEND: begin
                    start    = 1'b1;
                    start_pc = PC_PRE;
                end
                CMD_DONE: begin
                    start = 1'b1;
                    // third channel done (or stray index): shut down
                    if (chan_reg >= CHAN_LAST) begin
                        chan_next = 2'd0;
                        start_pc  = PC_SHUT;
                    end else begin
                        chan_next = chan_reg + 2'd1;
                        start_pc  = PC_PRE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg     <= 32'd0;
            thr_reg    <= THRESH_RESET;
            parity_reg <= 1'b0;
            chan_reg   <= 2'd0;
        end else begin
            parity_reg <= parity_next;
            chan_reg   <= chan_next;
            if (cfg_wr) begin
                if (paddr[2]) begin
                    thr_reg <= pwdata[7:0];
                end else begin
                    id_reg <= pwdata;
                end
            end
        end
    end

    bleaps_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_pc   (start_pc),
        .step       (step),
        .parity_odd (parity_reg),
        .busy       (busy),
        .ctrl       (ctrl)
    );

    bleaps_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .angle      (s_data.angle),
        .battery    (s_data.battery),
        .step       (step),
        .ctrl       (ctrl),
        .device_id  (id_reg),
        .threshold  (thr_reg),
        .parity_odd (parity_reg),
        .chan       (chan_reg),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data),
        .out_free   (out_free)
    );

`include "assert_macros.svh"

    `ASSERT_IMP(a_chan_range, 1'b1, chan_reg != 2'd3)
    `ASSERT_IMP(a_ctl_last, m_valid && m_data.kind != KIND_BYTE, m_data.last)
    `ASSERT_NXT(a_tick_flips, accept && cmd == CMD_TICK, parity_reg != $past(parity_reg))

endmodule

`default_nettype wire

/* tb/tb_ble_advert_packet_sequencer_top.sv */
module tb_ble_advert_packet_sequencer_top
    import bleaps_pkg::*;
();

    localparam int REG_DEVICE_ID = 0;
    localparam int REG_THRESHOLD = 1;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_PRINTS    = 20;
    localparam int HEADER_BYTES  = 11;
    localparam int NAME_BYTES    = 16;
    localparam int BEACON_BYTES  = 27;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_EVENTS  = 64;

    localparam logic [NAME_BYTES*8-1:0] NAME_RECORD =
        128'h0F084F70656E426561636F6E20546167;
    // angle and battery go into the two zero bytes before the trailing 0xC5
    localparam logic [BEACON_BYTES*8-1:0] BEACON_RECORD =
        216'h1AFF4C0002153B0C44C655A8F95532EB6AB26542FE1A00000000C5;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    in_word_t    s_data  = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    ble_advert_packet_sequencer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    // shadow of the block's state and registers
    logic        seq_parity    = 1'b0;
    logic [1:0]  chan_idx      = 2'd0;
    logic [31:0] cfg_device_id = 32'h0;
    logic [7:0]  cfg_threshold = THRESH_RESET;

    in_word_t  pending_events [$];
    out_word_t expected_words [$];

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int events_taken = 0;
    int words_seen   = 0;
    int tick_words   = 0;
    int shut_words   = 0;
    int byte_words   = 0;
    int cfg_writes   = 0;

    function automatic in_word_t make_event(input cmd_t c, input logic [7:0] ang,
                                            input logic [7:0] bat);
        in_word_t w;
        w.cmd     = c;
        w.angle   = ang;
        w.battery = bat;
        return w;
    endfunction

    function automatic logic [6:0] channel_freq(input logic [1:0] ch);
        logic [6:0] f;
        case (ch)
            2'd1:    f = 7'd26;
            2'd2:    f = 7'd80;
            default: f = 7'd2;
        endcase
        return f;
    endfunction

    function automatic logic [5:0] channel_white(input logic [1:0] ch);
        logic [5:0] c;
        case (ch)
            2'd1:    c = 6'd38;
            2'd2:    c = 6'd39;
            default: c = 6'd37;
        endcase
        return c;
    endfunction

    function automatic void push_word(input kind_t kd, input logic [7:0] b, input logic lst,
                                      input logic [6:0] f, input logic [5:0] wc,
                                      input logic conv, input logic osc);
        out_word_t w;
        w.kind              = kd;
        w.data_byte         = b;
        w.last              = lst;
        w.rf_frequency      = f;
        w.whitening_channel = wc;
        w.converter_on      = conv;
        w.oscillator_on     = osc;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_packet(input in_word_t ev);
        logic [HEADER_BYTES*8-1:0] header;
        logic [7:0] b;
        logic [1:0] ch;
        int rec_len;
        int total;
        int k;
        int r;
        ch = (chan_idx == 2'd3) ? 2'd0 : chan_idx;
        rec_len = seq_parity ? NAME_BYTES : BEACON_BYTES;
        header = {8'h42, 8'(HEADER_BYTES - 2 + rec_len), cfg_device_id, 16'h0000, 24'h020104};
        total = HEADER_BYTES + rec_len;
        for (k = 0; k < total; k++) begin
            r = k - HEADER_BYTES;
            if (k < HEADER_BYTES) begin
                b = header[8*(HEADER_BYTES-1-k) +: 8];
            end else if (seq_parity) begin
                b = NAME_RECORD[8*(NAME_BYTES-1-r) +: 8];
            end else if (r == BEACON_BYTES - 3) begin
                b = ev.angle;
            end else if (r == BEACON_BYTES - 2) begin
                b = ev.battery;
            end else begin
                b = BEACON_RECORD[8*(BEACON_BYTES-1-r) +: 8];
            end
            push_word(KIND_BYTE, b, k == total - 1, channel_freq(ch), channel_white(ch),
                      1'b0, 1'b0);
        end
    endfunction

    function automatic void predict_event(input in_word_t ev);
        case (ev.cmd)
            CMD_TICK: begin
                seq_parity = ~seq_parity;
                chan_idx   = 2'd0;
                push_word(KIND_TICK, 8'h00, 1'b1, 7'd0, 6'd0, ev.battery >= cfg_threshold, 1'b1);
            end
            CMD_SEND: begin
                predict_packet(ev);
            end
            CMD_DONE: begin
                if (chan_idx < CHAN_LAST) begin
                    chan_idx = chan_idx + 2'd1;
                    predict_packet(ev);
                end else begin
                    chan_idx = 2'd0;
                    push_word(KIND_SHUT, 8'h00, 1'b1, 7'd0, 6'd0, 1'b0, 1'b0);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.last !== want.last || got.rf_frequency !== want.rf_frequency ||
            got.whitening_channel !== want.whitening_channel ||
            got.converter_on !== want.converter_on ||
            got.oscillator_on !== want.oscillator_on)
            report_mismatch($sformatf(
                "word %0d: kind %0d/%0d byte %h/%h last %b/%b f %0d/%0d w %0d/%0d c %b/%b o %b/%b",
                words_seen, got.kind, want.kind, got.data_byte, want.data_byte,
                got.last, want.last, got.rf_frequency, want.rf_frequency,
                got.whitening_channel, want.whitening_channel,
                got.converter_on, want.converter_on, got.oscillator_on, want.oscillator_on));
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_event(s_data);
                events_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_data  <= pending_events.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_word(m_data);
                words_seen++;
                case (m_data.kind)
                    KIND_TICK: tick_words++;
                    KIND_SHUT: shut_words++;
                    default:   byte_words++;
                endcase
            end
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("tb_ble_advert_packet_sequencer_top: FAIL");
            $finish;
        end
    end

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_events.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge aclk);
        // a trailing ignored command may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DEVICE_ID)
            cfg_device_id = val;
        else
            cfg_threshold = val[7:0];
        cfg_writes++;
    endtask

    function automatic logic [7:0] battery_pick();
        int t;
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(255));
        t = int'(cfg_threshold) + $urandom_range(4) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
    endfunction

    task automatic queue_random(input int count);
        int made;
        int n;
        cmd_t c;
        made = 0;
        @(negedge aclk);
        while (made < count) begin
            if ($urandom_range(99) < 75) begin
                // full advertising round: tick, send, three transmit-done
                pending_events.push_back(make_event(CMD_TICK, 8'($urandom_range(255)),
                                                    battery_pick()));
                pending_events.push_back(make_event(CMD_SEND, 8'($urandom_range(255)),
                                                    8'($urandom_range(255))));
                for (n = 0; n < 3; n++)
                    pending_events.push_back(make_event(CMD_DONE, 8'($urandom_range(255)),
                                                        8'($urandom_range(255))));
                made += 5;
            end else begin
                c = cmd_t'($urandom_range(3));
                pending_events.push_back(make_event(c, 8'($urandom_range(255)), battery_pick()));
                if (c != CMD_NONE)
                    made++;
            end
        end
    endtask

    initial begin
        int p;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 22;
        recv_gap_pct = 86;
        @(negedge aclk);
        // reset settings: id 0, threshold at its reset value
        pending_events.push_back(make_event(CMD_SEND, 8'hFF, 8'h00));
        pending_events.push_back(make_event(CMD_DONE, 8'h00, 8'hFF));
        pending_events.push_back(make_event(CMD_DONE, 8'h5A, 8'hA5));
        pending_events.push_back(make_event(CMD_DONE, 8'h11, 8'h22));
        // transmit done with no send before it
        pending_events.push_back(make_event(CMD_DONE, 8'h33, 8'h44));
        pending_events.push_back(make_event(CMD_NONE, 8'hFF, 8'hFF));
        pending_events.push_back(make_event(CMD_TICK, 8'h00, THRESH_RESET - 8'd1));
        pending_events.push_back(make_event(CMD_SEND, 8'h01, 8'h02));
        pending_events.push_back(make_event(CMD_SEND, 8'h03, 8'h04));
        pending_events.push_back(make_event(CMD_DONE, 8'h05, 8'h06));
        pending_events.push_back(make_event(CMD_DONE, 8'h07, 8'h08));
        pending_events.push_back(make_event(CMD_DONE, 8'h09, 8'h0A));
        pending_events.push_back(make_event(CMD_TICK, 8'hFF, THRESH_RESET));
        pending_events.push_back(make_event(CMD_SEND, 8'h80, 8'h01));
        wait_drained();

        reg_write(REG_DEVICE_ID, 32'hFFFF_FFFF);
        reg_write(REG_THRESHOLD, 32'h0000_0000);
        @(negedge aclk);
        pending_events.push_back(make_event(CMD_TICK, 8'h00, 8'h00));
        pending_events.push_back(make_event(CMD_SEND, 8'hFF, 8'hFF));
        pending_events.push_back(make_event(CMD_TICK, 8'hAA, 8'hFF));
        pending_events.push_back(make_event(CMD_SEND, 8'h7F, 8'hFE));
        wait_drained();

        reg_write(REG_DEVICE_ID, 32'hA5C3_0F96);
        reg_write(REG_THRESHOLD, 32'h0000_00FF);
        @(negedge aclk);
        pending_events.push_back(make_event(CMD_TICK, 8'h55, 8'hFF));
        pending_events.push_back(make_event(CMD_TICK, 8'h55, 8'hFE));
        pending_events.push_back(make_event(CMD_SEND, 8'hC3, 8'h3C));
        pending_events.push_back(make_event(CMD_NONE, 8'h00, 8'h00));
        pending_events.push_back(make_event(CMD_DONE, 8'h96, 8'h69));
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    reg_write(REG_DEVICE_ID, 32'h0);
                    reg_write(REG_THRESHOLD, 32'd0);
                end
                1: begin
                    reg_write(REG_DEVICE_ID, 32'hFFFF_FFFF);
                    reg_write(REG_THRESHOLD, 32'd255);
                end
                default: begin
                    reg_write(REG_DEVICE_ID, $urandom);
                    reg_write(REG_THRESHOLD, 32'($urandom_range(10, 40)));
                end
            endcase
            @(negedge aclk);
            send_gap_pct = (p < 2) ? 22 : (p < 4) ? 86 : 0;
            recv_gap_pct = (p < 2) ? 86 : (p < 4) ? 22 : 0;
            if (p == 3) begin
                // sender holds off until every outstanding word is back
                queue_random(PHASE_EVENTS / 2);
                wait_drained();
                queue_random(PHASE_EVENTS - PHASE_EVENTS / 2);
            end else begin
                queue_random(PHASE_EVENTS);
            end
            wait_drained();
        end

        $display("events accepted %0d, words checked %0d (%0d bytes, %0d ticks, %0d shutdowns)",
                 events_taken, words_seen, byte_words, tick_words, shut_words);
        $display("register writes %0d across three handshake idle profiles, mismatches %0d",
                 cfg_writes, err_count);
        if (err_count == 0)
            $display("tb_ble_advert_packet_sequencer_top: PASS");
        else
            $display("tb_ble_advert_packet_sequencer_top: FAIL");
        $finish;
    end

endmodule
